>>> src/klc_pkg.sv
// shared types, codes and constants of the keypad lock controller
// no dependencies; imported by every module of the block
package klc_pkg;

  localparam int unsigned PasswordLength = 5;
  localparam int unsigned CntW = $clog2(PasswordLength + 1);
  localparam int unsigned IdxW = (PasswordLength > 1) ? $clog2(PasswordLength) : 1;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned NumW = $clog2(MaxResults + 1);
  localparam int unsigned PosW = $clog2(MaxResults);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChoiceOpen = 8'h2B;
  localparam logic [7:0] ChoiceChange = 8'h2D;

  typedef enum logic [1:0] {
    MODE_CHOICE = 2'd0,
    MODE_CHAR   = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    MSG_ADJUST    = 4'd0,
    MSG_SAVED     = 4'd1,
    MSG_MENU      = 4'd2,
    MSG_GETCHOICE = 4'd3,
    MSG_GETPW     = 4'd4,
    MSG_RIGHT     = 4'd5,
    MSG_RIGHTOPEN = 4'd6,
    MSG_WRONG     = 4'd7,
    MSG_LOCK      = 4'd8,
    MSG_OPENING   = 4'd9,
    MSG_OPENED    = 4'd10,
    MSG_CLOSING   = 4'd11,
    MSG_CLOSED    = 4'd12,
    MSG_INVALID   = 4'd13,
    MSG_MISMATCH  = 4'd14,
    MSG_MATCH     = 4'd15
  } msg_e;

  typedef enum logic [1:0] {
    MOT_OFF = 2'd0,
    MOT_CW  = 2'd1,
    MOT_CCW = 2'd2
  } motor_e;

  typedef enum logic [2:0] {
    CFG_MAX_WRONG   = 3'd0,
    CFG_LOCK_TICKS  = 3'd1,
    CFG_OPEN_END    = 3'd2,
    CFG_HOLD_END    = 3'd3,
    CFG_CLOSE_END   = 3'd4,
    CFG_MESSAGE_END = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] max_wrong_tries;
    logic [7:0] lock_ticks;
    logic [7:0] open_end_tick;
    logic [7:0] hold_end_tick;
    logic [7:0] close_end_tick;
    logic [7:0] message_end_tick;
  } cfg_t;

  // one result as it leaves the block, without the last flag
  typedef struct packed {
    msg_e   message;
    motor_e motor;
    logic   buzzer;
  } ent_t;

  // all results caused by one input item
  typedef struct packed {
    logic [NumW-1:0]          num;
    ent_t [MaxResults-1:0]    ent;
  } burst_t;

  function automatic ent_t mk_ent(msg_e msg, motor_e mot, logic buz);
    ent_t e;
    e.message = msg;
    e.motor = mot;
    e.buzzer = buz;
    return e;
  endfunction

endpackage

>>> src/klc_if.sv
// request channels of the keypad lock controller
// depends on nothing but plain logic types
interface klc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface klc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] message;
  logic [1:0] motor_drive;
  logic       alarm_on;
  logic       last;

  modport source (output valid, output message, output motor_drive, output alarm_on,
                  output last, input ready);
  modport sink (input valid, input message, input motor_drive, input alarm_on,
                input last, output ready);
endinterface

>>> src/klc_front.sv
// front end: accepts requests, runs the lock state machine, builds result bursts
// depends on klc_pkg and klc_in_if
module klc_front
  import klc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  klc_in_if.sink      in_ch,
  input  cfg_t        cfg_i,
  input  logic        q_ready_i,
  output logic        push_o,
  output burst_t      burst_o
);

  typedef enum logic [6:0] {
    PH_NEW       = 7'b0000001,
    PH_CONFIRM   = 7'b0000010,
    PH_CHOICE    = 7'b0000100,
    PH_CHECK     = 7'b0001000,
    PH_LOCKED    = 7'b0010000,
    PH_DOOR_OUT  = 7'b0100000,
    PH_DOOR_BACK = 7'b1000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            mis_q, mis_d;
  logic            chg_q, chg_d;
  logic [3:0]      wrong_q, wrong_d;
  logic [7:0]      tick_q, tick_d;
  motor_e          mot_q, mot_d;
  logic            buz_q, buz_d;

  logic [7:0] new_pw_q [PasswordLength];
  logic [7:0] sto_pw_q [PasswordLength];

  logic            accept;
  logic            wr_new, wr_sto;
  logic [IdxW-1:0] idx_sel;
  logic [7:0]      tick_inc;
  logic [3:0]      wrong_inc;
  logic [7:0]      d;
  logic            entry_ok;
  logic            entry_end;
  burst_t          burst;

  assign in_ch.ready = q_ready_i;
  assign accept = in_ch.valid && q_ready_i;
  assign d = in_ch.data_byte;
  assign idx_sel = idx_q[IdxW-1:0];
  assign tick_inc = (tick_q == 8'hFF) ? tick_q : tick_q + 8'd1;
  assign wrong_inc = wrong_q + 4'd1;
  assign entry_ok = (in_ch.mode == MODE_CHAR) && (idx_q < CntW'(PasswordLength));
  assign entry_end = (idx_q == CntW'(PasswordLength - 1));

  // next state and result burst for the accepted request
  always_comb begin
    phase_d = phase_q;
    idx_d = idx_q;
    mis_d = mis_q;
    chg_d = chg_q;
    wrong_d = wrong_q;
    tick_d = tick_q;
    mot_d = mot_q;
    buz_d = buz_q;
    wr_new = 1'b0;
    wr_sto = 1'b0;
    burst = '0;
    if (accept) begin
      unique case (phase_q)
        PH_NEW, PH_CONFIRM: begin
          if (entry_ok) begin
            // confirmation characters also land in the stored copy; it is only read
            // after a fully matched confirmation
            if (phase_q == PH_NEW) begin
              wr_new = 1'b1;
            end else begin
              wr_sto = 1'b1;
              if (new_pw_q[idx_sel] != d) mis_d = 1'b1;
            end
            idx_d = idx_q + CntW'(1);
            if (entry_end) begin
              idx_d = '0;
              mis_d = 1'b0;
              if (phase_q == PH_NEW) begin
                phase_d = PH_CONFIRM;
              end else if (mis_q || (new_pw_q[idx_sel] != d)) begin
                burst.ent[0] = mk_ent(MSG_MISMATCH, mot_q, buz_q);
                burst.num = NumW'(1);
                phase_d = PH_NEW;
              end else begin
                burst.ent[0] = mk_ent(MSG_MATCH, mot_q, buz_q);
                burst.ent[1] = mk_ent(MSG_SAVED, mot_q, buz_q);
                burst.ent[2] = mk_ent(MSG_MENU, mot_q, buz_q);
                burst.ent[3] = mk_ent(MSG_GETCHOICE, mot_q, buz_q);
                burst.num = NumW'(4);
                phase_d = PH_CHOICE;
              end
            end
          end
        end
        PH_CHOICE: begin
          if (in_ch.mode == MODE_CHOICE) begin
            if (d == ChoiceOpen || d == ChoiceChange) begin
              chg_d = (d == ChoiceChange);
              burst.ent[0] = mk_ent(MSG_GETPW, mot_q, buz_q);
              burst.num = NumW'(1);
              phase_d = PH_CHECK;
              idx_d = '0;
              mis_d = 1'b0;
            end else begin
              burst.ent[0] = mk_ent(MSG_INVALID, mot_q, buz_q);
              burst.ent[1] = mk_ent(MSG_MENU, mot_q, buz_q);
              burst.ent[2] = mk_ent(MSG_GETCHOICE, mot_q, buz_q);
              burst.num = NumW'(3);
            end
          end
        end
        PH_CHECK: begin
          if (entry_ok) begin
            if (sto_pw_q[idx_sel] != d) mis_d = 1'b1;
            idx_d = idx_q + CntW'(1);
            if (entry_end) begin
              idx_d = '0;
              mis_d = 1'b0;
              if (!(mis_q || (sto_pw_q[idx_sel] != d))) begin
                wrong_d = '0;
                if (chg_q) begin
                  burst.ent[0] = mk_ent(MSG_RIGHT, mot_q, buz_q);
                  burst.ent[1] = mk_ent(MSG_ADJUST, mot_q, buz_q);
                  burst.num = NumW'(2);
                  phase_d = PH_NEW;
                end else begin
                  burst.ent[0] = mk_ent(MSG_RIGHTOPEN, mot_q, buz_q);
                  burst.ent[1] = mk_ent(MSG_OPENING, MOT_CW, buz_q);
                  burst.num = NumW'(2);
                  tick_d = '0;
                  mot_d = MOT_CW;
                  phase_d = PH_DOOR_OUT;
                end
              end else if (wrong_inc >= cfg_i.max_wrong_tries) begin
                // lockout
                wrong_d = '0;
                tick_d = '0;
                buz_d = 1'b1;
                burst.ent[0] = mk_ent(MSG_LOCK, mot_q, 1'b1);
                burst.num = NumW'(1);
                phase_d = PH_LOCKED;
              end else begin
                wrong_d = wrong_inc;
                burst.ent[0] = mk_ent(MSG_WRONG, mot_q, buz_q);
                burst.ent[1] = mk_ent(MSG_GETPW, mot_q, buz_q);
                burst.num = NumW'(2);
              end
            end
          end
        end
        PH_LOCKED: begin
          if (in_ch.mode == MODE_TICK) begin
            tick_d = tick_inc;
            if (tick_inc >= cfg_i.lock_ticks) begin
              buz_d = 1'b0;
              tick_d = '0;
              burst.ent[0] = mk_ent(MSG_MENU, mot_q, 1'b0);
              burst.ent[1] = mk_ent(MSG_GETCHOICE, mot_q, 1'b0);
              burst.num = NumW'(2);
              phase_d = PH_CHOICE;
              idx_d = '0;
              mis_d = 1'b0;
            end
          end
        end
        PH_DOOR_OUT: begin
          if (in_ch.mode == MODE_TICK) begin
            tick_d = tick_inc;
            if (mot_q == MOT_CW) begin
              if (tick_inc >= cfg_i.open_end_tick) begin
                mot_d = MOT_OFF;
                burst.ent[0] = mk_ent(MSG_OPENED, MOT_OFF, buz_q);
                burst.num = NumW'(1);
              end
            end else if (tick_inc >= cfg_i.hold_end_tick) begin
              mot_d = MOT_CCW;
              phase_d = PH_DOOR_BACK;
              burst.ent[0] = mk_ent(MSG_CLOSING, MOT_CCW, buz_q);
              burst.num = NumW'(1);
            end
          end
        end
        PH_DOOR_BACK: begin
          if (in_ch.mode == MODE_TICK) begin
            tick_d = tick_inc;
            if (mot_q == MOT_CCW) begin
              if (tick_inc >= cfg_i.close_end_tick) begin
                mot_d = MOT_OFF;
                burst.ent[0] = mk_ent(MSG_CLOSED, MOT_OFF, buz_q);
                burst.num = NumW'(1);
              end
            end else if (tick_inc >= cfg_i.message_end_tick) begin
              // door sequence over, back to the menu
              mot_d = MOT_OFF;
              tick_d = '0;
              burst.ent[0] = mk_ent(MSG_MENU, MOT_OFF, buz_q);
              burst.ent[1] = mk_ent(MSG_GETCHOICE, MOT_OFF, buz_q);
              burst.num = NumW'(2);
              phase_d = PH_CHOICE;
              idx_d = '0;
              mis_d = 1'b0;
            end
          end
        end
        default: begin
          phase_d = PH_NEW;
          idx_d = '0;
          mis_d = 1'b0;
        end
      endcase
    end
  end

  assign push_o = accept && (burst.num != '0);
  assign burst_o = burst;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NEW;
      idx_q <= '0;
      mis_q <= 1'b0;
      chg_q <= 1'b0;
      wrong_q <= '0;
      tick_q <= '0;
      mot_q <= MOT_OFF;
      buz_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q <= idx_d;
      mis_q <= mis_d;
      chg_q <= chg_d;
      wrong_q <= wrong_d;
      tick_q <= tick_d;
      mot_q <= mot_d;
      buz_q <= buz_d;
    end
  end

  // password stores, written one character per request
  always_ff @(posedge clk_i) begin
    if (wr_new) new_pw_q[idx_sel] <= d;
    if (wr_sto) sto_pw_q[idx_sel] <= d;
  end

endmodule

>>> src/klc_queue.sv
// short queue of result bursts between front end and back end
// depends on klc_pkg
module klc_queue
  import klc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  burst_t burst_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output burst_t burst_o
);

  burst_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_q, wr_d;
  logic [QPtrW-1:0]   rd_q, rd_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign ready_o = (cnt_q != QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop = pop_i && valid_o;
  assign burst_o = mem_q[rd_q];

  // pointer wrap and fill count
  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
    if (do_pop) rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + QCntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= burst_i;
  end

endmodule

>>> src/klc_back.sv
// back end: plays out each burst as single results on the output channel
// depends on klc_pkg and klc_out_if
module klc_back
  import klc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  burst_t     q_burst_i,
  output logic       pop_o,
  klc_out_if.source  out_ch
);

  burst_t          cur_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            busy_q, busy_d;
  logic            fire;
  logic            is_last;
  ent_t            ent;

  assign ent = cur_q.ent[pos_q];
  assign is_last = (NumW'(pos_q) + NumW'(1) == cur_q.num);
  assign fire = busy_q && out_ch.ready;
  assign pop_o = q_valid_i && (!busy_q || (fire && is_last));

  assign out_ch.valid = busy_q;
  assign out_ch.message = ent.message;
  assign out_ch.motor_drive = ent.motor;
  assign out_ch.alarm_on = ent.buzzer;
  assign out_ch.last = is_last;

  // step through the current burst, load the next one at its end
  always_comb begin
    pos_d = pos_q;
    busy_d = busy_q;
    if (pop_o) begin
      pos_d = '0;
      busy_d = 1'b1;
    end else if (fire) begin
      if (is_last) busy_d = 1'b0;
      else pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      busy_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_burst_i;
  end

endmodule

>>> src/keypad_lock_controller_unit.sv
// top level of the keypad lock controller: configuration registers and the three stages
// depends on klc_pkg, klc_if, klc_front, klc_queue and klc_back
//
// Door-lock controller fed password characters, menu choices and timer ticks on in_ch;
// status results leave on out_ch, each with the motor and buzzer levels and a last flag
// on the final result of a request. A request is taken every cycle while the two-entry
// burst queue has room; the front end classifies it and updates the lock state in that
// same cycle. Results leave one per cycle from the back end while out_ch is ready; a
// request with several results holds the output until all are taken, and the output
// rate sets the sustained rate for such requests. Configuration writes take effect at once
// and need no handshake; indexes beyond the six registers are ignored.
module keypad_lock_controller_unit
  import klc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  klc_in_if.sink     in_ch,
  klc_out_if.source  out_ch,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t   cfg_q;
  logic   q_ready;
  logic   push;
  burst_t push_burst;
  logic   pop;
  logic   q_valid;
  burst_t q_burst;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_wrong_tries <= 4'd3;
      cfg_q.lock_ticks <= 8'd10;
      cfg_q.open_end_tick <= 8'd30;
      cfg_q.hold_end_tick <= 8'd39;
      cfg_q.close_end_tick <= 8'd66;
      cfg_q.message_end_tick <= 8'd70;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_WRONG:   cfg_q.max_wrong_tries <= cfg_data_i[3:0];
        CFG_LOCK_TICKS:  cfg_q.lock_ticks <= cfg_data_i;
        CFG_OPEN_END:    cfg_q.open_end_tick <= cfg_data_i;
        CFG_HOLD_END:    cfg_q.hold_end_tick <= cfg_data_i;
        CFG_CLOSE_END:   cfg_q.close_end_tick <= cfg_data_i;
        CFG_MESSAGE_END: cfg_q.message_end_tick <= cfg_data_i;
        default: ;
      endcase
    end
  end

  klc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .cfg_i     (cfg_q),
    .q_ready_i (q_ready),
    .push_o    (push),
    .burst_o   (push_burst)
  );

  klc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .burst_i (push_burst),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .burst_o (q_burst)
  );

  klc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_burst_i (q_burst),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule
